// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the range min/max query block: item
// field widths, function codes, sequencer states and node word layout.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // field widths of one item
    localparam int VAL_BITS   = 30;
    localparam int POS_BITS   = 11;
    localparam int COUNT_BITS = 11;

    // stream word widths
    localparam int IN_TDATA_BITS  = 64;
    localparam int OUT_TDATA_BITS = 64;

    // count of positions in use after reset
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

    // identity values of an empty range
    localparam logic [VAL_BITS-1:0] VAL_ONES = {VAL_BITS{1'b1}};
    localparam logic [VAL_BITS-1:0] VAL_ZERO = '0;

    // function carried in tuser
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_LEAF,
        ST_LD_WALK,
        ST_Q_SETUP,
        ST_Q_WALK,
        ST_Q_DONE
    } t_state;

    // one tree node: minimum and maximum of its span
    typedef struct packed {
        logic [VAL_BITS-1:0] max_val;
        logic [VAL_BITS-1:0] min_val;
    } t_mm;

    // which candidates the combine unit takes in
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_cmp_ctl;

endpackage

// File: rtl/rmq_cmp_unit.sv
// ----------------------------------------------------------------------------
// rmq_cmp_unit
// Shared min/max combine unit: folds up to two node words into the
// running minimum and maximum. Used for path updates and range walks.
// ----------------------------------------------------------------------------
module rmq_cmp_unit
    import rmq_pkg::*;
(
    input  t_mm      i_acc,
    input  t_mm      i_a,
    input  t_mm      i_b,
    input  t_cmp_ctl i_ctl,
    output t_mm      o_res
);

    t_mm mid;

    // fold first candidate
    always_comb begin
        mid = i_acc;
        if (i_ctl.en_a) begin
            if (i_a.min_val < i_acc.min_val) mid.min_val = i_a.min_val;
            if (i_a.max_val > i_acc.max_val) mid.max_val = i_a.max_val;
        end
    end

    // fold second candidate
    always_comb begin
        o_res = mid;
        if (i_ctl.en_b) begin
            if (i_b.min_val < mid.min_val) o_res.min_val = i_b.min_val;
            if (i_b.max_val > mid.max_val) o_res.max_val = i_b.max_val;
        end
    end

endmodule

// File: rtl/range_min_max_query_unit.sv
// Load word: accept, leaf write, then one parent write per level for log2(DEPTH) levels,
//   then back to idle for the next word; no result word.
// Query word: setup, a walk up the levels, then hand-off to the output register; the next
//   word is taken only after the hand-off, and a held output word stalls the hand-off.
// One combine unit and the two-read node memory set the pace, one level a cycle.
// Synchronous reset idles the sequencer, clears output valid, sets element_count to 1024; no tree clear.
// ----------------------------------------------------------------------------
// range_min_max_query_unit
// Segment tree of minima and maxima over 1-based positions. An in-range load word
// writes a leaf and refreshes its path to the root; a query word walks
// the tree bottom-up and returns the minimum and maximum of the range.
// ----------------------------------------------------------------------------
module range_min_max_query_unit
    import rmq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: element_count
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [COUNT_BITS-1:0]     i_cfg_data,
    // input stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // position[10:0], elem_value[40:11], range_low[51:41], range_high[62:52], zero[63]
    input  logic [IN_TDATA_BITS-1:0]  i_s_tdata,
    // func[0]
    input  logic                      i_s_tuser,
    // output stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // range_min[29:0], range_max[59:30], zero[63:60]
    output logic [OUT_TDATA_BITS-1:0] o_m_tdata
);

    localparam int NODES = 2 * DEPTH;
    localparam int AW    = $clog2(NODES);
    localparam int NW    = AW + 1;
    localparam int CW    = (NW > POS_BITS) ? NW : POS_BITS;

    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    // input fields
    logic [POS_BITS-1:0] in_position;
    logic [VAL_BITS-1:0] in_value;
    logic [POS_BITS-1:0] in_low;
    logic [POS_BITS-1:0] in_high;
    t_func               in_func;

    assign in_position = i_s_tdata[10:0];
    assign in_value    = i_s_tdata[40:11];
    assign in_low      = i_s_tdata[51:41];
    assign in_high     = i_s_tdata[62:52];
    assign in_func     = t_func'(i_s_tuser);

    // registers
    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_ec, n_ec;
    logic [NW-1:0]         r_node, n_node;
    logic [NW-1:0]         r_l, n_l;
    logic [NW-1:0]         r_r, n_r;
    logic                  r_pend_a, n_pend_a;
    logic                  r_pend_b, n_pend_b;
    t_mm                   r_acc, n_acc;
    t_mm                   r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic [POS_BITS-1:0]   r_lo, n_lo;
    logic [POS_BITS-1:0]   r_hi, n_hi;
    logic [VAL_BITS-1:0]   r_val, n_val;

    // node memory and its registered read ports
    t_mm                   r_tree [NODES];
    t_mm                   r_rd_a;
    t_mm                   r_rd_b;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    t_mm                   mem_wd;
    logic [AW-1:0]         mem_ra_a;
    logic [AW-1:0]         mem_ra_b;

    // combine unit hookup
    t_cmp_ctl              cmp_ctl;
    t_mm                   cmp_res;

    // load and query address math
    logic                  s_accept;
    logic                  pos_ok;
    logic [CW-1:0]         lo_c;
    logic [CW-1:0]         hi_c;
    logic [CW-1:0]         limit_c;
    logic                  q_empty;
    logic [NW-1:0]         parent;
    logic [NW-1:0]         r_minus;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(OUT_TDATA_BITS - 2 * VAL_BITS){1'b0}},
                          r_out.max_val, r_out.min_val};

    assign pos_ok  = (in_position != '0) && (CW'(in_position) <= DEPTH_C);
    assign lo_c    = (r_lo == '0) ? CW'(1) : CW'(r_lo);
    assign limit_c = (CW'(r_ec) < DEPTH_C) ? CW'(r_ec) : DEPTH_C;
    assign hi_c    = (CW'(r_hi) < limit_c) ? CW'(r_hi) : limit_c;
    assign q_empty = lo_c > hi_c;
    assign parent  = r_node >> 1;
    assign r_minus = r_r - ONE_N;

    rmq_cmp_unit u_cmp (
        .i_acc (r_acc),
        .i_a   (r_rd_a),
        .i_b   (r_rd_b),
        .i_ctl (cmp_ctl),
        .o_res (cmp_res)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ec        <= COUNT_RESET;
            r_out_valid <= 1'b0;
            r_pend_a    <= 1'b0;
            r_pend_b    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ec        <= n_ec;
            r_out_valid <= n_out_valid;
            r_pend_a    <= n_pend_a;
            r_pend_b    <= n_pend_b;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_l    <= n_l;
        r_r    <= n_r;
        r_acc  <= n_acc;
        r_out  <= n_out;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_val  <= n_val;
    end

    // node memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_tree[mem_ra_a];
        r_rd_b <= r_tree[mem_ra_b];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ec        = r_ec;
        n_node      = r_node;
        n_l         = r_l;
        n_r         = r_r;
        n_pend_a    = r_pend_a;
        n_pend_b    = r_pend_b;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_val       = r_val;

        mem_we      = 1'b0;
        mem_wa      = r_node[AW-1:0];
        mem_wd      = '{max_val: r_val, min_val: r_val};
        mem_ra_a    = r_l[AW-1:0];
        mem_ra_b    = r_minus[AW-1:0];
        cmp_ctl     = '{en_a: 1'b0, en_b: 1'b0};

        if (i_cfg_valid) begin
            n_ec = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_lo  = in_low;
                    n_hi  = in_high;
                    n_val = in_value;
                    if (in_func == FUNC_QUERY) begin
                        n_state = ST_Q_SETUP;
                    end else if (pos_ok) begin
                        n_node  = DEPTH_N + NW'(in_position) - ONE_N;
                        n_state = ST_LD_LEAF;
                    end
                end
            end

            // write the leaf, fetch its sibling
            ST_LD_LEAF: begin
                mem_we   = 1'b1;
                mem_wa   = r_node[AW-1:0];
                mem_wd   = '{max_val: r_val, min_val: r_val};
                mem_ra_a = r_node[AW-1:0] ^ AW'(1);
                n_acc    = '{max_val: r_val, min_val: r_val};
                n_state  = ST_LD_WALK;
            end

            // combine with sibling, write parent, fetch parent's sibling
            ST_LD_WALK: begin
                cmp_ctl  = '{en_a: 1'b1, en_b: 1'b0};
                mem_we   = 1'b1;
                mem_wa   = parent[AW-1:0];
                mem_wd   = cmp_res;
                mem_ra_a = parent[AW-1:0] ^ AW'(1);
                n_acc    = cmp_res;
                n_node   = parent;
                if (parent == ONE_N) begin
                    n_state = ST_IDLE;
                end
            end

            // clip the range and set the walk bounds
            ST_Q_SETUP: begin
                n_acc    = '{max_val: VAL_ZERO, min_val: VAL_ONES};
                n_pend_a = 1'b0;
                n_pend_b = 1'b0;
                n_l      = DEPTH_N + NW'(lo_c) - ONE_N;
                n_r      = DEPTH_N + NW'(hi_c);
                n_state  = q_empty ? ST_Q_DONE : ST_Q_WALK;
            end

            // fold last cycle's reads, issue this level's reads
            ST_Q_WALK: begin
                cmp_ctl = '{en_a: r_pend_a, en_b: r_pend_b};
                n_acc   = cmp_res;
                if (r_l < r_r) begin
                    n_pend_a = r_l[0];
                    n_pend_b = r_r[0];
                    n_l      = (r_l + NW'(r_l[0])) >> 1;
                    n_r      = r_r >> 1;
                end else begin
                    n_pend_a = 1'b0;
                    n_pend_b = 1'b0;
                    n_state  = ST_Q_DONE;
                end
            end

            // hand the result to the output register
            ST_Q_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // walk bounds never cross
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_WALK) |-> (r_l <= r_r))
        else $error("query walk bounds crossed");

    // path update never goes above the root
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LD_WALK) |-> (r_node > ONE_N))
        else $error("load walk reached past root");

    // a result appears only from the done state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_Q_DONE))
        else $error("result word without a finished query");

    // a query word always enters setup
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_func == FUNC_QUERY)) |=> (r_state == ST_Q_SETUP))
        else $error("query word not taken to setup");
`endif

endmodule

// File: tb/range_min_max_query_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_max_query_unit_tb
// Self-checking bench for the range min/max query block. A local segment
// tree predicts every query answer at the moment its word is accepted. The
// answers are checked in order against the output stream while both sides
// idle and stall at random and element_count moves between settings.
// ----------------------------------------------------------------------------
module range_min_max_query_unit_tb
    import rmq_pkg::*;
();

    localparam int TREE_DEPTH    = 1024;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int MAX_REPORTS   = 40;
    localparam int POS_MAX       = (1 << POS_BITS) - 1;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [COUNT_BITS-1:0]     i_cfg_data  = '0;
    logic                      i_s_tvalid  = 1'b0;
    logic                      o_s_tready;
    // position[10:0], elem_value[40:11], range_low[51:41], range_high[62:52], zero[63]
    logic [IN_TDATA_BITS-1:0]  i_s_tdata   = '0;
    // func[0]
    logic                      i_s_tuser   = 1'b0;
    logic                      o_m_tvalid;
    logic                      i_m_tready  = 1'b0;
    // range_min[29:0], range_max[59:30], zero[63:60]
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;

    // predictor state
    logic [VAL_BITS-1:0]   min_tree [2*TREE_DEPTH];
    logic [VAL_BITS-1:0]   max_tree [2*TREE_DEPTH];
    logic [COUNT_BITS-1:0] element_count_model = COUNT_RESET;
    t_mm                   expected_extrema [$];

    int error_count      = 0;
    int cycle_count      = 0;
    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int sink_hold_cycles = 0;

    range_min_max_query_unit #(
        .DEPTH(TREE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: point update along the leaf-to-root path
    // ------------------------------------------------------------------------
    function automatic void tree_store(int unsigned pos, logic [VAL_BITS-1:0] val);
        int unsigned p;
        if (pos < 1 || pos > TREE_DEPTH)
            return;
        p = TREE_DEPTH + pos - 1;
        min_tree[p] = val;
        max_tree[p] = val;
        while (p > 1) begin
            p = p >> 1;
            min_tree[p] = (min_tree[2*p] < min_tree[2*p+1]) ? min_tree[2*p] : min_tree[2*p+1];
            max_tree[p] = (max_tree[2*p] > max_tree[2*p+1]) ? max_tree[2*p] : max_tree[2*p+1];
        end
    endfunction

    // bottom-up range walk, clipped to element_count and the tree size
    function automatic t_mm tree_query(int unsigned lo, int unsigned hi);
        t_mm         acc;
        int unsigned lim;
        int unsigned l;
        int unsigned r;
        acc.min_val = VAL_ONES;
        acc.max_val = VAL_ZERO;
        lim = (element_count_model < TREE_DEPTH) ? element_count_model : TREE_DEPTH;
        if (lo < 1)
            lo = 1;
        if (hi > lim)
            hi = lim;
        if (lo > hi)
            return acc;
        l = TREE_DEPTH + lo - 1;
        r = TREE_DEPTH + hi;
        while (l < r) begin
            if (l[0]) begin
                if (min_tree[l] < acc.min_val) acc.min_val = min_tree[l];
                if (max_tree[l] > acc.max_val) acc.max_val = max_tree[l];
                l++;
            end
            if (r[0]) begin
                r--;
                if (min_tree[r] < acc.min_val) acc.min_val = min_tree[r];
                if (max_tree[r] > acc.max_val) acc.max_val = max_tree[r];
            end
            l = l >> 1;
            r = r >> 1;
        end
        return acc;
    endfunction

    function automatic logic [POS_BITS-1:0] to_pos_field(int x);
        if (x < 0)
            return '0;
        if (x > POS_MAX)
            return POS_BITS'(POS_MAX);
        return POS_BITS'(x);
    endfunction

    function automatic logic [VAL_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_ZERO;
            1:       return VAL_ONES;
            default: return VAL_BITS'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_mm want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_extrema.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result word with no query pending, got %h", $time,
                             o_m_tdata);
            end else begin
                want = expected_extrema.pop_front();
                if (o_m_tdata[VAL_BITS-1:0] !== want.min_val) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: range_min mismatch, expected %h, actual %h", $time,
                                 want.min_val, o_m_tdata[VAL_BITS-1:0]);
                end
                if (o_m_tdata[2*VAL_BITS-1:VAL_BITS] !== want.max_val) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: range_max mismatch, expected %h, actual %h", $time,
                                 want.max_val, o_m_tdata[2*VAL_BITS-1:VAL_BITS]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one word, with random idle cycles in front of it
    // ------------------------------------------------------------------------
    task automatic send_word(t_func func, logic [POS_BITS-1:0] pos,
                             logic [VAL_BITS-1:0] val, logic [POS_BITS-1:0] lo,
                             logic [POS_BITS-1:0] hi);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {1'b0, 31'($urandom), 32'($urandom)};
            i_s_tuser  <= 1'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {1'b0, hi, lo, val, pos};
        forever begin
            @(posedge i_clk);
            if (o_s_tready)
                break;
        end
        if (func == FUNC_LOAD)
            tree_store(pos, val);
        else
            expected_extrema = {expected_extrema, tree_query(lo, hi)};
    endtask

    // load: range fields are don't-care and carry noise
    task automatic send_load(int pos, logic [VAL_BITS-1:0] val);
        send_word(FUNC_LOAD, to_pos_field(pos), val, POS_BITS'($urandom),
                  POS_BITS'($urandom));
    endtask

    // query: position and value are don't-care and carry noise
    task automatic send_query(int lo, int hi);
        send_word(FUNC_QUERY, POS_BITS'($urandom), VAL_BITS'($urandom), to_pos_field(lo),
                  to_pos_field(hi));
    endtask

    // lower valid and wait until the block has gone quiet
    task automatic wait_quiet();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_extrema.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_element_count(int count);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= COUNT_BITS'(count);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        element_count_model = COUNT_BITS'(count);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one random word; loads outside the tree are ignored and not counted
    task automatic send_random_item(output bit counted);
        int lo;
        int hi;
        counted = 1'b1;
        if ($urandom_range(99) < 40) begin
            if ($urandom_range(9) == 0) begin
                counted = 1'b0;
                send_load($urandom_range(1) ? 0 : $urandom_range(TREE_DEPTH + 1, POS_MAX),
                          pick_value());
            end else begin
                send_load($urandom_range(1, TREE_DEPTH), pick_value());
            end
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    lo = $urandom_range(1, TREE_DEPTH);
                    hi = lo + $urandom_range(0, 16);
                end
                4, 5: begin
                    lo = $urandom_range(0, POS_MAX);
                    hi = $urandom_range(0, POS_MAX);
                end
                6: begin
                    lo = $urandom_range(1) ? 0 : 1;
                    hi = $urandom_range(1) ? POS_MAX : TREE_DEPTH;
                end
                7: begin
                    hi = $urandom_range(0, TREE_DEPTH);
                    lo = hi + $urandom_range(1, 8);
                end
                8: begin
                    lo = $urandom_range(1, TREE_DEPTH);
                    hi = lo;
                end
                default: begin
                    lo = int'(element_count_model) - $urandom_range(0, 8);
                    hi = int'(element_count_model) + $urandom_range(0, 8) - 4;
                end
            endcase
            send_query(lo, hi);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // extremes, ignored loads, clipping and empty ranges
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_load(1, VAL_ZERO);
        send_load(2, VAL_ONES);
        send_load(TREE_DEPTH, 30'h1555_5555);
        send_load(0, 30'd5);
        send_load(TREE_DEPTH + 1, 30'd7);
        send_load(POS_MAX, 30'd9);
        send_query(1, 1);
        send_query(1, 2);
        send_query(2, 2);
        send_query(0, 2);
        send_query(2, 1);
        send_query(0, 0);
        send_query(TREE_DEPTH, POS_MAX);
        send_query(TREE_DEPTH + 1, POS_MAX);
        send_query(TREE_DEPTH, TREE_DEPTH);
        // element_count at the small end, then zero and all ones
        set_element_count(2);
        send_query(1, POS_MAX);
        set_element_count(1);
        send_query(1, POS_MAX);
        send_query(2, 2);
        set_element_count(0);
        send_query(1, 1);
        set_element_count(POS_MAX);
        send_query(TREE_DEPTH, POS_MAX);
        wait_quiet();
    endtask

    // load every position once, in shuffled order
    task automatic test_fill_tree();
        int order [TREE_DEPTH];
        int j;
        int tmp;
        src_idle_pct   = 16;
        sink_stall_pct = 16;
        set_element_count(TREE_DEPTH);
        for (int i = 0; i < TREE_DEPTH; i++)
            order[i] = i + 1;
        for (int i = TREE_DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TREE_DEPTH; i++)
            send_load(order[i], VAL_BITS'($urandom));
        wait_quiet();
    endtask

    task automatic test_random_phase(int count, int idle_pct, int stall_pct, int n_items);
        int  sent;
        bit  counted;
        sent = 0;
        set_element_count(count);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < n_items) begin
            send_random_item(counted);
            if (counted)
                sent++;
        end
        wait_quiet();
    endtask

    // receiver holds off while the sender keeps offering queries
    task automatic test_backpressure();
        set_element_count(TREE_DEPTH);
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 400;
        repeat (30) send_query($urandom_range(0, TREE_DEPTH), $urandom_range(1, POS_MAX));
        wait_quiet();
    endtask

    // sender drains the block completely between bursts
    task automatic test_sender_pause();
        bit counted;
        src_idle_pct   = 16;
        sink_stall_pct = 16;
        repeat (3) begin
            repeat (10) send_random_item(counted);
            wait_quiet();
        end
    endtask

    // main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_tree();
        test_random_phase(TREE_DEPTH, 0, 0, 40);
        test_random_phase(TREE_DEPTH, 52, 0, 30);
        test_random_phase(TREE_DEPTH, 0, 52, 30);
        test_random_phase(TREE_DEPTH, 16, 16, 25);
        test_random_phase(1, 16, 16, 10);
        test_random_phase(POS_MAX, 52, 52, 20);
        test_random_phase($urandom_range(2, TREE_DEPTH - 1), 0, 0, 20);
        test_random_phase(0, 0, 0, 10);
        test_backpressure();
        test_sender_pause();
        test_random_phase(TREE_DEPTH, 16, 16, 20);

        wait_quiet();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
